>>> sv/mwf_pkg.sv
package mwf_pkg;

	localparam int GRID_COLS  = 16;
	localparam int GRID_ROWS  = 16;
	localparam int CELL_COUNT = GRID_COLS * GRID_ROWS;
	localparam int CELL_W     = $clog2(CELL_COUNT);
	localparam int POS_W      = 4;
	localparam int MUL_W      = CELL_W + POS_W;

	localparam logic [1:0] MODE_EXPLORE = 2'd0;
	localparam logic [1:0] MODE_RETURN  = 2'd1;
	localparam logic [1:0] MODE_FAST    = 2'd2;
	localparam logic [1:0] MODE_DONE    = 2'd3;

	localparam logic [2:0] TURN_NONE   = 3'd0;
	localparam logic [2:0] TURN_LEFT   = 3'd1;
	localparam logic [2:0] TURN_RIGHT  = 3'd2;
	localparam logic [2:0] TURN_RIGHT2 = 3'd3;
	localparam logic [2:0] TURN_LEFT2  = 3'd4;

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_BOXED   = 2'd1;
	localparam logic [1:0] ST_OFFGRID = 2'd2;

	localparam logic [1:0] HEAD_NORTH = 2'd0;
	localparam logic [1:0] HEAD_EAST  = 2'd1;
	localparam logic [1:0] HEAD_SOUTH = 2'd2;
	localparam logic [1:0] HEAD_WEST  = 2'd3;

	localparam logic CFG_GOAL_X = 1'b0;
	localparam logic CFG_GOAL_Y = 1'b1;

	localparam logic [POS_W-1:0] GOAL_X_RST = POS_W'(2);
	localparam logic [POS_W-1:0] GOAL_Y_RST = POS_W'(6);

	// Write requests from the navigator to the cell tables.
	typedef struct packed {
		logic              vis_set;
		logic [CELL_W-1:0] vis_addr;
		logic              dep_we;
		logic [CELL_W-1:0] dep_addr;
		logic [1:0]        dep_data;
		logic              ret_req;
		logic [CELL_W-1:0] ret_addr;
		logic [1:0]        ret_data;
	} tbl_wr_t;

	typedef struct packed {
		logic [2:0]       turn_code;
		logic             move_forward;
		logic [POS_W-1:0] new_x;
		logic [POS_W-1:0] new_y;
		logic [1:0]       new_heading;
		logic [1:0]       mode;
		logic [1:0]       status;
	} res_t;

	function automatic logic [CELL_W-1:0] cell_of(input logic [POS_W-1:0] x,
		input logic [POS_W-1:0] y);
		logic [MUL_W-1:0] lin;
		lin = MUL_W'(y) * MUL_W'(GRID_COLS) + MUL_W'(x);
		return lin[CELL_W-1:0];
	endfunction

endpackage

>>> sv/maze_wall_follower_replay.sv
// Maze navigator: each transfer on the input channel is one move. For each item
// the cell tables (departure and return headings) are read into registers at
// the robot's current cell; once the output register is free, the decision is
// made, the tables and position are written back and the result goes to the
// output register. No item is taken before the last is done; the visited map
// sits in flip-flops cleared by reset, so no clearing pass is needed. One
// finished result can wait in the output register while the next is in work.
module maze_wall_follower_replay import mwf_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic             cfg_index,
	input  logic [POS_W-1:0] cfg_data,
	input  logic             in_valid,
	output logic             in_stall,
	input  logic             wall_left,
	input  logic             wall_front,
	input  logic             wall_right,
	input  logic             wall_back,
	output logic             out_valid,
	input  logic             out_stall,
	output logic [2:0]       turn_code,
	output logic             move_forward,
	output logic [POS_W-1:0] new_x,
	output logic [POS_W-1:0] new_y,
	output logic [1:0]       new_heading,
	output logic [1:0]       mode,
	output logic [1:0]       status
);

	logic              busy, fire, in_take, out_free;
	logic [CELL_W-1:0] rd_addr;
	logic [1:0]        dep_rd, ret_rd;
	tbl_wr_t           wr;
	res_t              res;
	res_t              res_q;
	logic              out_valid_q;

	assign in_stall = busy;
	assign in_take  = in_valid && !busy;
	assign out_free = !out_valid_q || !out_stall;

	mwf_nav u_nav (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_take   (in_take),
		.walls     ({wall_back, wall_right, wall_front, wall_left}),
		.out_free  (out_free),
		.dep_rd    (dep_rd),
		.ret_rd    (ret_rd),
		.busy      (busy),
		.fire      (fire),
		.rd_addr   (rd_addr),
		.wr        (wr),
		.res       (res)
	);

	mwf_tables u_tables (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_addr (rd_addr),
		.wr      (wr),
		.dep_rd  (dep_rd),
		.ret_rd  (ret_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			res_q <= res;
		end
	end

	assign out_valid    = out_valid_q;
	assign turn_code    = res_q.turn_code;
	assign move_forward = res_q.move_forward;
	assign new_x        = res_q.new_x;
	assign new_y        = res_q.new_y;
	assign new_heading  = res_q.new_heading;
	assign mode         = res_q.mode;
	assign status       = res_q.status;

endmodule

>>> sv/mwf_tables.sv
module mwf_tables import mwf_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [CELL_W-1:0] rd_addr,
	input  tbl_wr_t           wr,
	output logic [1:0]        dep_rd,
	output logic [1:0]        ret_rd
);

	logic [1:0]            dep_mem [CELL_COUNT];
	logic [1:0]            ret_mem [CELL_COUNT];
	logic [CELL_COUNT-1:0] visited_q;
	logic                  ret_we;

	// A return heading is kept only for the first entry into a cell.
	assign ret_we = wr.ret_req && !visited_q[wr.ret_addr];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			visited_q <= '0;
		end else if (wr.vis_set) begin
			visited_q[wr.vis_addr] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr.dep_we) begin
			dep_mem[wr.dep_addr] <= wr.dep_data;
		end
		if (ret_we) begin
			ret_mem[wr.ret_addr] <= wr.ret_data;
		end
		dep_rd <= dep_mem[rd_addr];
		ret_rd <= ret_mem[rd_addr];
	end

endmodule

>>> sv/mwf_nav.sv
module mwf_nav import mwf_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic              cfg_index,
	input  logic [POS_W-1:0]  cfg_data,
	input  logic              in_take,
	input  logic [3:0]        walls,
	input  logic              out_free,
	input  logic [1:0]        dep_rd,
	input  logic [1:0]        ret_rd,
	output logic              busy,
	output logic              fire,
	output logic [CELL_W-1:0] rd_addr,
	output tbl_wr_t           wr,
	output res_t              res
);

	logic [POS_W-1:0] goal_x_q, goal_y_q;
	logic [POS_W-1:0] pos_x_q, pos_y_q;
	logic [1:0]       heading_q;
	logic [1:0]       mode_q;
	logic             busy_s1;
	logic [3:0]       walls_s1;

	logic [CELL_W-1:0] cur_cell;
	logic [1:0]        hn, target, diff;
	logic [2:0]        turn;
	logic [1:0]        st, mode_n;
	logic              attempt, ok, moved;
	logic [POS_W-1:0]  nx, ny;

	assign busy     = busy_s1;
	assign fire     = busy_s1 && out_free;
	assign cur_cell = cell_of(pos_x_q, pos_y_q);
	assign rd_addr  = cur_cell;

	always_comb begin
		turn    = TURN_NONE;
		hn      = heading_q;
		st      = ST_OK;
		attempt = 1'b0;
		target  = (mode_q == MODE_RETURN) ? ret_rd : dep_rd;
		diff    = target - heading_q;
		case (mode_q)
			MODE_EXPLORE: begin
				attempt = 1'b1;
				if (!walls_s1[0]) begin
					turn = TURN_LEFT;
					hn   = heading_q - 2'd1;
				end else if (!walls_s1[1]) begin
					turn = TURN_NONE;
				end else if (!walls_s1[2]) begin
					turn = TURN_RIGHT;
					hn   = heading_q + 2'd1;
				end else if (!walls_s1[3]) begin
					turn = TURN_RIGHT2;
					hn   = heading_q + 2'd2;
				end else begin
					st      = ST_BOXED;
					attempt = 1'b0;
				end
			end
			MODE_RETURN, MODE_FAST: begin
				attempt = 1'b1;
				hn      = target;
				case (diff)
					2'd1:    turn = TURN_RIGHT;
					2'd2:    turn = TURN_LEFT2;
					2'd3:    turn = TURN_LEFT;
					default: turn = TURN_NONE;
				endcase
			end
			default: begin
			end
		endcase

		nx = pos_x_q;
		ny = pos_y_q;
		ok = 1'b0;
		unique case (hn)
			HEAD_NORTH: begin
				ok = ((POS_W+1)'(pos_y_q) + (POS_W+1)'(1)) < (POS_W+1)'(GRID_ROWS);
				ny = pos_y_q + POS_W'(1);
			end
			HEAD_EAST: begin
				ok = ((POS_W+1)'(pos_x_q) + (POS_W+1)'(1)) < (POS_W+1)'(GRID_COLS);
				nx = pos_x_q + POS_W'(1);
			end
			HEAD_SOUTH: begin
				ok = pos_y_q != '0;
				ny = pos_y_q - POS_W'(1);
			end
			HEAD_WEST: begin
				ok = pos_x_q != '0;
				nx = pos_x_q - POS_W'(1);
			end
			default: ok = 1'b0;
		endcase

		moved = attempt && ok;
		if (attempt && !ok) begin
			st = ST_OFFGRID;
		end

		mode_n = mode_q;
		if (moved) begin
			case (mode_q)
				MODE_EXPLORE: begin
					if (nx == goal_x_q && ny == goal_y_q) begin
						mode_n = (nx == '0 && ny == '0) ? MODE_DONE : MODE_RETURN;
					end
				end
				MODE_RETURN: begin
					if (nx == '0 && ny == '0) begin
						mode_n = (nx == goal_x_q && ny == goal_y_q) ? MODE_DONE : MODE_FAST;
					end
				end
				MODE_FAST: begin
					if (nx == goal_x_q && ny == goal_y_q) begin
						mode_n = MODE_DONE;
					end
				end
				default: mode_n = mode_q;
			endcase
		end
	end

	always_comb begin
		wr.vis_set  = fire && (mode_q == MODE_EXPLORE);
		wr.vis_addr = cur_cell;
		wr.dep_we   = fire && (mode_q == MODE_EXPLORE) && moved;
		wr.dep_addr = cur_cell;
		wr.dep_data = hn;
		wr.ret_req  = wr.dep_we;
		wr.ret_addr = cell_of(nx, ny);
		wr.ret_data = hn + 2'd2;

		res.turn_code    = turn;
		res.move_forward = moved;
		res.new_x        = moved ? nx : pos_x_q;
		res.new_y        = moved ? ny : pos_y_q;
		res.new_heading  = attempt ? hn : heading_q;
		res.mode         = mode_n;
		res.status       = st;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			goal_x_q  <= GOAL_X_RST;
			goal_y_q  <= GOAL_Y_RST;
			pos_x_q   <= '0;
			pos_y_q   <= '0;
			heading_q <= HEAD_NORTH;
			mode_q    <= MODE_EXPLORE;
			busy_s1   <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_GOAL_X: goal_x_q <= cfg_data;
					default:    goal_y_q <= cfg_data;
				endcase
			end
			if (fire) begin
				pos_x_q   <= res.new_x;
				pos_y_q   <= res.new_y;
				heading_q <= res.new_heading;
				mode_q    <= mode_n;
			end
			if (in_take) begin
				busy_s1 <= 1'b1;
			end else if (fire) begin
				busy_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			walls_s1 <= walls;
		end
	end

endmodule

>>> sim/maze_wall_follower_replay_tb.sv
`timescale 1ns / 100ps

module maze_wall_follower_replay_tb;
	import mwf_pkg::*;

	// Tracks the robot as the block should see it and holds the moves still due.
	class move_tracker;
		logic [POS_W-1:0] goal_x, goal_y, pos_x, pos_y;
		logic [1:0]       run_mode, heading;
		bit               visited [CELL_COUNT];
		logic [1:0]       depart_dir [CELL_COUNT];
		logic [1:0]       return_dir [CELL_COUNT];
		res_t             moves_due [$];
		int unsigned      mismatches;

		function new();
			goal_x = GOAL_X_RST;
			goal_y = GOAL_Y_RST;
			pos_x = '0;
			pos_y = '0;
			run_mode = MODE_EXPLORE;
			heading = HEAD_NORTH;
			foreach (visited[i]) begin
				visited[i] = 0;
				depart_dir[i] = HEAD_NORTH;
				return_dir[i] = HEAD_NORTH;
			end
			mismatches = 0;
		endfunction

		function int slot(input logic [POS_W-1:0] x, y);
			return int'(y) * GRID_COLS + int'(x);
		endfunction

		function bit neighbor(input logic [1:0] dir, input logic [POS_W-1:0] x, y,
			output logic [POS_W-1:0] nx, ny);
			nx = x;
			ny = y;
			case (dir)
				HEAD_NORTH: begin
					if (int'(y) + 1 >= GRID_ROWS) return 0;
					ny = y + 1'b1;
				end
				HEAD_EAST: begin
					if (int'(x) + 1 >= GRID_COLS) return 0;
					nx = x + 1'b1;
				end
				HEAD_SOUTH: begin
					if (y == 0) return 0;
					ny = y - 1'b1;
				end
				default: begin
					if (x == 0) return 0;
					nx = x - 1'b1;
				end
			endcase
			return 1;
		endfunction

		// Left-hand rule; walls are {left, front, right, back}. Returns 0 when boxed in.
		function bit pick_heading(input logic [3:0] walls, input logic [1:0] h,
			output logic [1:0] nh, output logic [2:0] turn);
			nh = h;
			turn = TURN_NONE;
			if (!walls[3]) begin
				turn = TURN_LEFT;
				nh = h - 2'd1;
			end else if (!walls[2]) begin
				turn = TURN_NONE;
			end else if (!walls[1]) begin
				turn = TURN_RIGHT;
				nh = h + 2'd1;
			end else if (!walls[0]) begin
				turn = TURN_RIGHT2;
				nh = h + 2'd2;
			end else begin
				return 0;
			end
			return 1;
		endfunction

		function logic [2:0] turn_needed(input logic [1:0] from, input logic [1:0] to);
			logic [1:0] diff;
			diff = to - from;
			case (diff)
				2'd1: return TURN_RIGHT;
				2'd2: return TURN_LEFT2;
				2'd3: return TURN_LEFT;
				default: return TURN_NONE;
			endcase
		endfunction

		function void take_move(input logic [3:0] walls);
			res_t             r;
			int               here, there;
			logic [1:0]       nh, target;
			logic [2:0]       turn;
			logic [POS_W-1:0] nx, ny;
			r = '0;
			here = slot(pos_x, pos_y);
			case (run_mode)
				MODE_EXPLORE: begin
					visited[here] = 1;
					if (!pick_heading(walls, heading, nh, turn)) begin
						r.status = ST_BOXED;
					end else begin
						r.turn_code = turn;
						heading = nh;
						if (neighbor(nh, pos_x, pos_y, nx, ny)) begin
							r.move_forward = 1'b1;
							depart_dir[here] = nh;
							pos_x = nx;
							pos_y = ny;
							there = slot(nx, ny);
							if (!visited[there]) return_dir[there] = nh + 2'd2;
							if (pos_x == goal_x && pos_y == goal_y)
								run_mode = (pos_x == 0 && pos_y == 0) ? MODE_DONE : MODE_RETURN;
						end else begin
							r.status = ST_OFFGRID;
						end
					end
				end
				MODE_RETURN, MODE_FAST: begin
					target = (run_mode == MODE_RETURN) ? return_dir[here] : depart_dir[here];
					r.turn_code = turn_needed(heading, target);
					heading = target;
					if (neighbor(target, pos_x, pos_y, nx, ny)) begin
						r.move_forward = 1'b1;
						pos_x = nx;
						pos_y = ny;
						if (run_mode == MODE_RETURN) begin
							if (pos_x == 0 && pos_y == 0)
								run_mode = (pos_x == goal_x && pos_y == goal_y) ?
									MODE_DONE : MODE_FAST;
						end else if (pos_x == goal_x && pos_y == goal_y) begin
							run_mode = MODE_DONE;
						end
					end else begin
						r.status = ST_OFFGRID;
					end
				end
				default: ;
			endcase
			r.new_x = pos_x;
			r.new_y = pos_y;
			r.new_heading = heading;
			r.mode = run_mode;
			moves_due.push_back(r);
		endfunction

		function void miss(input string what);
			mismatches++;
			if (mismatches <= 10) $display("%0t: %s", $time, what);
		endfunction

		function void match_move(input res_t got);
			res_t want;
			if (moves_due.size() == 0) begin
				miss("move result with no move outstanding");
				return;
			end
			want = moves_due.pop_front();
			if (got !== want)
				miss($sformatf({"move mismatch: expected turn %0d mv %0d x %0d y %0d hd %0d ",
					"mode %0d st %0d, got turn %0d mv %0d x %0d y %0d hd %0d mode %0d st %0d"},
					want.turn_code, want.move_forward, want.new_x, want.new_y,
					want.new_heading, want.mode, want.status,
					got.turn_code, got.move_forward, got.new_x, got.new_y,
					got.new_heading, got.mode, got.status));
		endfunction
	endclass

	// Opening moves near the origin: boxed in, both grid edges, every explore turn.
	localparam logic [3:0] OPENING_WALLS [19] = '{
		4'b1111, 4'b0000, 4'b1011, 4'b1100, 4'b1110, 4'b0111, 4'b1101, 4'b1110,
		4'b0101, 4'b1111, 4'b1100, 4'b1000, 4'b0011, 4'b1110, 4'b1010, 4'b0001,
		4'b1101, 4'b1110, 4'b0110
	};

	logic             clk = 1'b0;
	logic             arst_n;
	logic             cfg_we;
	logic             cfg_index;
	logic [POS_W-1:0] cfg_data;
	logic             in_valid;
	logic             in_stall;
	logic             wall_left, wall_front, wall_right, wall_back;
	logic             out_valid;
	logic             out_stall;
	logic [2:0]       turn_code;
	logic             move_forward;
	logic [POS_W-1:0] new_x, new_y;
	logic [1:0]       new_heading, mode, status;

	move_tracker trk;
	int          idle_pct = 0;
	int          stall_pct = 0;
	int          hold_left = 0;

	maze_wall_follower_replay dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.wall_left(wall_left),
		.wall_front(wall_front),
		.wall_right(wall_right),
		.wall_back(wall_back),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.turn_code(turn_code),
		.move_forward(move_forward),
		.new_x(new_x),
		.new_y(new_y),
		.new_heading(new_heading),
		.mode(mode),
		.status(status)
	);

	always #5 clk = ~clk;

	task feed(input logic [3:0] w);
		while ($urandom_range(0, 99) < idle_pct) begin
			@(negedge clk);
			in_valid <= 1'b0;
		end
		@(negedge clk);
		in_valid <= 1'b1;
		wall_left <= w[3];
		wall_front <= w[2];
		wall_right <= w[1];
		wall_back <= w[0];
		@(posedge clk);
		while (in_stall) @(posedge clk);
		trk.take_move(w);
	endtask

	// Stops offering moves and waits until every outstanding move has come back.
	task settle();
		int waited;
		@(negedge clk);
		in_valid <= 1'b0;
		waited = 0;
		while (trk.moves_due.size() != 0 && waited < 5000) begin
			@(posedge clk);
			waited++;
		end
		repeat (4) @(posedge clk);
	endtask

	task set_goal(input logic [POS_W-1:0] gx, input logic [POS_W-1:0] gy);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= CFG_GOAL_X;
		cfg_data <= gx;
		@(negedge clk);
		cfg_index <= CFG_GOAL_Y;
		cfg_data <= gy;
		@(negedge clk);
		cfg_we <= 1'b0;
		trk.goal_x = gx;
		trk.goal_y = gy;
	endtask

	// Random walls, except that a move into the goal is turned into a boxed-in cell
	// so that exploring goes on as long as wanted.
	task explore_run(input int count);
		logic [3:0]       w;
		logic [1:0]       nh;
		logic [2:0]       turn;
		logic [POS_W-1:0] nx, ny;
		repeat (count) begin
			w = 4'($urandom);
			if (trk.pick_heading(w, trk.heading, nh, turn) &&
				trk.neighbor(nh, trk.pos_x, trk.pos_y, nx, ny) &&
				nx == trk.goal_x && ny == trk.goal_y)
				w = 4'b1111;
			feed(w);
		end
	endtask

	initial begin
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_left > 0) begin
				out_stall <= 1'b1;
				hold_left--;
			end else begin
				out_stall <= ($urandom_range(0, 99) < stall_pct);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			trk.match_move(res_t'({turn_code, move_forward, new_x, new_y,
				new_heading, mode, status}));
	end

	initial begin
		logic [POS_W-1:0] gx, gy;
		logic [1:0]       dir, rel;
		logic [3:0]       w;
		trk = new();
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = CFG_GOAL_X;
		cfg_data = '0;
		in_valid = 1'b0;
		wall_left = 1'b0;
		wall_front = 1'b0;
		wall_right = 1'b0;
		wall_back = 1'b0;
		repeat (6) @(negedge clk);
		arst_n <= 1'b1;

		foreach (OPENING_WALLS[i]) feed(OPENING_WALLS[i]);
		settle();

		// Back to back with one long receiver hold-off so the block backs up.
		set_goal(4'd15, 4'd0);
		hold_left = 60;
		explore_run(430);
		settle();

		set_goal(4'd0, 4'd15);
		idle_pct = 70;
		explore_run(430);
		settle();

		set_goal(4'd0, 4'd0);
		idle_pct = 0;
		stall_pct = 70;
		explore_run(430);
		settle();

		do begin
			gx = 4'($urandom);
			gy = 4'($urandom);
		end while ((gx == 0 && gy == 0) || (gx == trk.pos_x && gy == trk.pos_y));
		set_goal(gx, gy);
		idle_pct = 11;
		stall_pct = 11;
		explore_run(430);

		// Steer toward the goal, with some random moves mixed in.
		while (trk.run_mode == MODE_EXPLORE) begin
			if (trk.pos_x != trk.goal_x && (trk.pos_y == trk.goal_y || $urandom_range(0, 1)))
				dir = (trk.pos_x < trk.goal_x) ? HEAD_EAST : HEAD_WEST;
			else if (trk.pos_y != trk.goal_y)
				dir = (trk.pos_y < trk.goal_y) ? HEAD_NORTH : HEAD_SOUTH;
			else
				dir = 2'($urandom);
			rel = dir - trk.heading;
			case (rel)
				2'd3: w = {1'b0, 3'($urandom)};
				2'd0: w = {2'b10, 2'($urandom)};
				2'd1: w = {3'b110, 1'($urandom)};
				default: w = 4'b1110;
			endcase
			if ($urandom_range(0, 3) == 0) w = 4'($urandom);
			feed(w);
		end

		// Return and fast run ignore the walls; a few more moves once done.
		while (trk.run_mode != MODE_DONE) feed(4'($urandom));
		repeat (8) feed(4'($urandom));
		settle();

		if (trk.moves_due.size() != 0)
			trk.miss($sformatf("%0d moves never came back", trk.moves_due.size()));
		if (trk.mismatches == 0) begin
			$display("maze_wall_follower_replay test passed");
		end else begin
			$display("maze_wall_follower_replay test failed");
		end
		$finish;
	end

	initial begin
		#5_000_000;
		$display("maze_wall_follower_replay test failed");
		$finish;
	end

endmodule
